FILE: hw/rtl/olst_pkg.sv
`default_nettype none
package olst_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMD_W  = 4;
  localparam int LOC_W  = 8;
  localparam int STAT_W = 3;
  localparam int POS_W  = 5;

  localparam logic [CMD_W-1:0] CMD_INS_FRONT = 4'd0;
  localparam logic [CMD_W-1:0] CMD_INS_BACK  = 4'd1;
  localparam logic [CMD_W-1:0] CMD_INS_AT    = 4'd2;
  localparam logic [CMD_W-1:0] CMD_INS_AFTER = 4'd3;
  localparam logic [CMD_W-1:0] CMD_DEL_FRONT = 4'd4;
  localparam logic [CMD_W-1:0] CMD_DEL_BACK  = 4'd5;
  localparam logic [CMD_W-1:0] CMD_DEL_AT    = 4'd6;
  localparam logic [CMD_W-1:0] CMD_DEL_AFTER = 4'd7;
  localparam logic [CMD_W-1:0] CMD_SIZE      = 4'd8;
  localparam logic [CMD_W-1:0] CMD_SEARCH    = 4'd9;
  localparam logic [CMD_W-1:0] CMD_DUMP      = 4'd10;

  localparam logic [STAT_W-1:0] STAT_OK      = 3'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY   = 3'd1;
  localparam logic [STAT_W-1:0] STAT_BADLOC  = 3'd2;
  localparam logic [STAT_W-1:0] STAT_NOKEY   = 3'd3;
  localparam logic [STAT_W-1:0] STAT_NOAFTER = 3'd4;
  localparam logic [STAT_W-1:0] STAT_FULL    = 3'd5;

  typedef struct packed {
    logic [CMD_W-1:0]         command;
    logic signed [DATA_W-1:0] value;
    logic [LOC_W-1:0]         location;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] data;
    logic [POS_W-1:0]         position;
    logic                     last;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_LOAD,
    OP_FROM_LO,
    OP_FROM_HI
  } cell_op_t;

  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } olst_state_t;

  typedef struct packed {
    logic             ins;
    logic             del;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] rd_idx;
  } chain_ctl_t;

  typedef struct packed {
    logic                     found;
    logic [IDX_W-1:0]         match_idx;
    logic signed [DATA_W-1:0] rd_data;
  } chain_stat_t;

endpackage
`default_nettype wire

FILE: hw/rtl/olst_cell.sv
`default_nettype none
module olst_cell import olst_pkg::*; (
  input  wire logic                     clk,
  input  wire cell_op_t                 op,
  input  wire logic signed [DATA_W-1:0] load_data,
  input  wire logic signed [DATA_W-1:0] lo_data,
  input  wire logic signed [DATA_W-1:0] hi_data,
  input  wire logic signed [DATA_W-1:0] key,
  output logic signed [DATA_W-1:0]      data,
  output logic                          match
);

  logic signed [DATA_W-1:0] data_r;
  logic signed [DATA_W-1:0] data_nxt;

  always_comb begin
    case (op)
      OP_HOLD:    data_nxt = data_r;
      OP_LOAD:    data_nxt = load_data;
      OP_FROM_LO: data_nxt = lo_data;
      OP_FROM_HI: data_nxt = hi_data;
      default:    data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data  = data_r;
  assign match = (data_r == key);

endmodule
`default_nettype wire

FILE: hw/rtl/olst_chain.sv
`default_nettype none
module olst_chain import olst_pkg::*; (
  input  wire logic                     clk,
  input  wire chain_ctl_t               ctl,
  input  wire logic signed [DATA_W-1:0] value,
  input  wire logic [CNT_W-1:0]         count,
  output chain_stat_t                   stat
);

  logic signed [DATA_W-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]         cell_match;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] lo;
    logic signed [DATA_W-1:0] hi;
    cell_op_t                 op;

    if (i == 0) begin : g_first
      assign lo = value;
    end else begin : g_lo
      assign lo = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign hi = cell_data[i];
    end else begin : g_hi
      assign hi = cell_data[i+1];
    end

    always_comb begin
      op = OP_HOLD;
      if (ctl.ins) begin
        if (IDX_W'(i) == ctl.idx) begin
          op = OP_LOAD;
        end else if (IDX_W'(i) > ctl.idx) begin
          op = OP_FROM_LO;
        end
      end else if (ctl.del && (IDX_W'(i) >= ctl.idx)) begin
        op = OP_FROM_HI;
      end
    end

    olst_cell u_cell (
      .clk       (clk),
      .op        (op),
      .load_data (value),
      .lo_data   (lo),
      .hi_data   (hi),
      .key       (value),
      .data      (cell_data[i]),
      .match     (cell_match[i])
    );
  end

  logic [DEPTH-1:0] hit;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      hit[i] = cell_match[i] && (CNT_W'(i) < count);
    end
  end

  always_comb begin
    stat.found     = |hit;
    stat.match_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (hit[i]) begin
        stat.match_idx = IDX_W'(i);
      end
    end
    stat.rd_data = cell_data[ctl.rd_idx];
  end

endmodule
`default_nettype wire

FILE: hw/rtl/ordered_list_store_core.sv
// Ordered list of up to DEPTH signed 32-bit values, held in a row of cells that
// shift toward the back on insert and toward the front on delete. Every command
// except dump completes when taken: the cells compare the key in parallel and
// move in the same clock edge, and the single result goes to an output register,
// so a new command is taken each cycle while results are drained. A dump of an
// empty list answers with STAT_EMPTY; otherwise the dump loads nothing when taken,
// then count results follow, one per cycle while results drain, with input held
// off until the last is loaded. Undefined commands are consumed with no result.
`default_nettype none
module ordered_list_store_core import olst_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_item
);

  olst_state_t      state_r, state_nxt;
  logic [IDX_W-1:0] ptr_r, ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r, out_item_nxt;

  chain_ctl_t  ctl;
  chain_stat_t cstat;

  logic             accept;
  logic             slot_free;
  logic             res_valid;
  out_item_t        res;
  logic             empty;
  logic             full;
  logic             loc_ok;
  logic [IDX_W-1:0] loc_idx;
  logic [IDX_W-1:0] next_idx;
  logic [IDX_W-1:0] back_idx;
  logic             after_ok;

  olst_chain u_chain (
    .clk   (clk),
    .ctl   (ctl),
    .value (in_item.value),
    .count (count_r),
    .stat  (cstat)
  );

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r == ST_DUMP) || !slot_free;
  assign accept    = in_valid && !in_stall;

  assign empty    = (count_r == '0);
  assign full     = (count_r == CNT_W'(DEPTH));
  assign loc_ok   = (in_item.location != '0) &&
                    (in_item.location <= LOC_W'(count_r));
  assign loc_idx  = IDX_W'(in_item.location - LOC_W'(1));
  assign next_idx = cstat.match_idx + IDX_W'(1);
  assign back_idx = IDX_W'(count_r - CNT_W'(1));
  assign after_ok = (CNT_W'(cstat.match_idx) + CNT_W'(1)) < count_r;

  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    count_nxt     = count_r;
    ctl.ins       = 1'b0;
    ctl.del       = 1'b0;
    ctl.idx       = '0;
    ctl.rd_idx    = '0;
    res_valid     = 1'b0;
    res.status    = STAT_OK;
    res.data      = '0;
    res.position  = '0;
    res.last      = 1'b1;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          res_valid = 1'b1;
          case (in_item.command)
            CMD_INS_FRONT: begin
              if (full) begin
                res.status = STAT_FULL;
              end else begin
                ctl.ins = 1'b1;
              end
            end
            CMD_INS_BACK: begin
              if (full) begin
                res.status = STAT_FULL;
              end else begin
                ctl.ins = 1'b1;
                ctl.idx = IDX_W'(count_r);
              end
            end
            CMD_INS_AT: begin
              if (!loc_ok) begin
                res.status = STAT_BADLOC;
              end else if (full) begin
                res.status = STAT_FULL;
              end else begin
                ctl.ins = 1'b1;
                ctl.idx = loc_idx;
              end
            end
            CMD_INS_AFTER: begin
              if (!cstat.found) begin
                res.status = STAT_NOKEY;
              end else if (full) begin
                res.status = STAT_FULL;
              end else begin
                ctl.ins = 1'b1;
                ctl.idx = next_idx;
              end
            end
            CMD_DEL_FRONT, CMD_DEL_BACK: begin
              if (empty) begin
                res.status = STAT_EMPTY;
              end else begin
                ctl.del    = 1'b1;
                ctl.idx    = (in_item.command == CMD_DEL_FRONT) ? '0 : back_idx;
                ctl.rd_idx = ctl.idx;
                res.data   = cstat.rd_data;
              end
            end
            CMD_DEL_AT: begin
              if (empty) begin
                res.status = STAT_EMPTY;
              end else if (!loc_ok) begin
                res.status = STAT_BADLOC;
              end else begin
                ctl.del    = 1'b1;
                ctl.idx    = loc_idx;
                ctl.rd_idx = loc_idx;
                res.data   = cstat.rd_data;
              end
            end
            CMD_DEL_AFTER: begin
              if (empty) begin
                res.status = STAT_EMPTY;
              end else if (!cstat.found) begin
                res.status = STAT_NOKEY;
              end else if (!after_ok) begin
                res.status = STAT_NOAFTER;
              end else begin
                ctl.del    = 1'b1;
                ctl.idx    = next_idx;
                ctl.rd_idx = next_idx;
                res.data   = cstat.rd_data;
              end
            end
            CMD_SIZE: begin
              res.position = POS_W'(count_r);
            end
            CMD_SEARCH: begin
              if (empty) begin
                res.status = STAT_EMPTY;
              end else if (!cstat.found) begin
                res.status = STAT_NOKEY;
              end else begin
                res.position = POS_W'(CNT_W'(cstat.match_idx) + CNT_W'(1));
              end
            end
            CMD_DUMP: begin
              if (empty) begin
                res.status = STAT_EMPTY;
              end else begin
                res_valid = 1'b0;
                ptr_nxt   = '0;
                state_nxt = ST_DUMP;
              end
            end
            default: begin
              res_valid = 1'b0;
            end
          endcase
          if (ctl.ins) begin
            count_nxt = count_r + CNT_W'(1);
          end else if (ctl.del) begin
            count_nxt = count_r - CNT_W'(1);
          end
        end
      end
      ST_DUMP: begin
        ctl.rd_idx = ptr_r;
        if (slot_free) begin
          res_valid = 1'b1;
          res.data  = cstat.rd_data;
          res.last  = (ptr_r == back_idx);
          if (res.last) begin
            state_nxt = ST_IDLE;
          end else begin
            ptr_nxt = ptr_r + IDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
      out_item_nxt  = res;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ptr_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("element count above capacity");

  a_dump_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DUMP) |-> in_stall)
    else $error("input taken during dump");

  a_count_held_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> $stable(count_r))
    else $error("list changed while result held");

  a_dump_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DUMP) |-> (count_r != '0) && (CNT_W'(ptr_r) < count_r))
    else $error("dump pointer beyond stored elements");

endmodule
`default_nettype wire
